// ===== hw/rtl/rusi_pkg.sv =====
// Package for the unit-sphere ray intersection pipeline: widths, item types
// and the sideband records that travel alongside the arithmetic units.
// No dependencies.
package rusi_pkg;

  // Coordinate format: signed, CW bits with FB fraction bits.
  localparam int CW   = 32;
  localparam int FB   = 16;
  // Derived widths of the exact integer arithmetic.
  localparam int PRW  = 2 * CW;      // one coordinate product
  localparam int AW   = 2 * CW;      // d.d, unsigned
  localparam int BCW  = 2 * CW + 1;  // d.o and o.o - 1, signed
  localparam int QW   = 4 * CW;      // B^2 and A*|C|
  localparam int DSW  = 4 * CW + 2;  // discriminant, signed
  localparam int RW   = CW + FB;     // integer square root of a non-negative discriminant
  localparam int NSW  = 2 * CW + 2;  // numerator -B +/- R, signed
  localparam int NMW  = 2 * CW + 1;  // magnitude of the numerator
  localparam int PMW  = CW + NMW;    // magnitude of d_i * N
  localparam int NUMW = PMW + 1;     // 2|p| + A
  localparam int DENW = AW + 1;      // 2A
  localparam int QB   = CW + 2;      // quotient bits kept before saturation
  localparam int UW   = QB + 2;      // origin plus signed quotient
  localparam int LIMB = 16;          // multiplier limb width

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [2:0][CW-1:0]   vec3_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [BCW-1:0] UNIT_SQ = BCW'(1) << (2 * FB);

  // Input item: one ray in the sphere's local space.
  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } ray_t;

  // Result item.
  typedef struct packed {
    logic   hit;
    coord_t impact_x;
    coord_t impact_y;
    coord_t impact_z;
    logic   saturated;
  } impact_t;

  // Sideband through the discriminant multipliers.
  typedef struct packed {
    vec3_t              o;
    vec3_t              d;
    logic [AW-1:0]      a;
    logic [BCW-1:0]     b;
    logic               c_neg;
    logic               c_zero;
    logic               a_zero;
  } sb_d_t;

  // Sideband through the square root.
  typedef struct packed {
    vec3_t              o;
    vec3_t              d;
    logic [AW-1:0]      a;
    logic [BCW-1:0]     b;
    logic               c_neg;
    logic               hit;
    logic               c_zero;
  } sb_r_t;

  // Sideband through the impact multipliers.
  typedef struct packed {
    vec3_t              o;
    logic [AW-1:0]      a;
    logic [2:0]         neg;
    logic               hit;
    logic               c_zero;
  } sb_p_t;

  // Sideband through the dividers.
  typedef struct packed {
    vec3_t              o;
    logic [2:0]         neg;
    logic               hit;
    logic               c_zero;
  } sb_q_t;

endpackage

// ===== hw/rtl/ray_unit_sphere_intersect.sv =====
// Ray against the unit sphere at the origin, exact fixed point, fully pipelined.
// Depends on rusi_pkg, rusi_mul, rusi_sqrt and rusi_div.
//
// Use: a ray (origin and direction, signed Q16.16) enters on the ray channel and
// one result item (hit, impact point, saturated flag) leaves on the result
// channel for every ray, in order. Both channels move an item at a clock edge
// where valid is high and stall is low.
// Throughput: one ray per cycle while ray_stall is low. From acceptance to
// result_valid an item passes the dot-product stages, the limb-serial
// discriminant multipliers, the discriminant register, the bit-per-stage
// square root, the numerator register, the impact multipliers, the
// bit-per-stage dividers and the output register.
// Reset (rst, synchronous) clears every valid bit in the pipe, the output
// register and the skid register; no item is in flight afterwards.
// Stall: while result_stall holds, one more finished item is parked in a skid
// register; from the next cycle ray_stall is high and the whole pipe holds
// still until the receiver takes the waiting item.
module ray_unit_sphere_intersect (
  input  logic              clk,
  input  logic              rst,
  input  logic              ray_valid,
  output logic              ray_stall,
  input  rusi_pkg::ray_t    ray,
  output logic              result_valid,
  input  logic              result_stall,
  output rusi_pkg::impact_t result
);

  import rusi_pkg::*;

  logic    en;
  logic    skid_full;
  impact_t skid;

  assign en        = !skid_full;
  assign ray_stall = skid_full;

  // Stage 1: all coordinate products.
  vec3_t                 o_in, d_in, o1, d1;
  logic                  v1;
  logic signed [PRW-1:0] oo1 [3];
  logic signed [PRW-1:0] dd1 [3];
  logic signed [PRW-1:0] od1 [3];

  assign o_in = {ray.origin_z, ray.origin_y, ray.origin_x};
  assign d_in = {ray.dir_z, ray.dir_y, ray.dir_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= ray_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o1 <= o_in;
      d1 <= d_in;
      for (int i = 0; i < 3; i++) begin
        oo1[i] <= $signed(o_in[i]) * $signed(o_in[i]);
        dd1[i] <= $signed(d_in[i]) * $signed(d_in[i]);
        od1[i] <= $signed(d_in[i]) * $signed(o_in[i]);
      end
    end
  end

  // Stage 2: quadratic coefficients A = d.d, B = d.o, C = o.o - 1.
  logic                  v2;
  vec3_t                 o2, d2;
  logic [AW-1:0]         a2;
  logic signed [BCW-1:0] b2, c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o2 <= o1;
      d2 <= d1;
      a2 <= AW'(dd1[0]) + AW'(dd1[1]) + AW'(dd1[2]);
      b2 <= BCW'(od1[0]) + BCW'(od1[1]) + BCW'(od1[2]);
      c2 <= BCW'(oo1[0]) + BCW'(oo1[1]) + BCW'(oo1[2]) - UNIT_SQ;
    end
  end

  // Discriminant products |B|^2 and A*|C|.
  logic [BCW-1:0]         bmag_w, cmag_w;
  sb_d_t                  sbd_in, sbd;
  logic [1:0][QW-1:0]     dprod;
  logic                   vd;

  assign bmag_w = b2[BCW-1] ? -b2 : b2;
  assign cmag_w = c2[BCW-1] ? -c2 : c2;

  always_comb begin
    sbd_in.o      = o2;
    sbd_in.d      = d2;
    sbd_in.a      = a2;
    sbd_in.b      = b2;
    sbd_in.c_neg  = c2[BCW-1];
    sbd_in.c_zero = (c2 == '0);
    sbd_in.a_zero = (a2 == '0);
  end

  rusi_mul #(
    .LANES (2),
    .AW    (AW),
    .BW    (AW),
    .LB    (LIMB),
    .SW    ($bits(sb_d_t))
  ) u_mul_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .a         ({a2, bmag_w[AW-1:0]}),
    .b         ({cmag_w[AW-1:0], bmag_w[AW-1:0]}),
    .in_side   (sbd_in),
    .out_valid (vd),
    .p         (dprod),
    .out_side  (sbd)
  );

  // Discriminant and the hit decision.
  logic [DSW-1:0] disc;
  logic           d_neg, d_zero, miss;
  sb_r_t          sbr_next, sbr;
  logic           vr;
  logic [2*RW-1:0] rad;

  always_comb begin
    if (sbd.c_neg) begin
      disc = DSW'(dprod[0]) + DSW'(dprod[1]);
    end else begin
      disc = DSW'(dprod[0]) - DSW'(dprod[1]);
    end
    d_neg  = disc[DSW-1];
    d_zero = (disc == '0);
    // Outside and moving away: both roots at or behind the origin, unless tangent.
    miss   = sbd.a_zero || d_neg || (!d_zero && !sbd.c_neg && !sbd.b[BCW-1]);
    sbr_next.o      = sbd.o;
    sbr_next.d      = sbd.d;
    sbr_next.a      = sbd.a;
    sbr_next.b      = sbd.b;
    sbr_next.c_neg  = sbd.c_neg;
    sbr_next.hit    = sbd.c_zero || !miss;
    sbr_next.c_zero = sbd.c_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad <= d_neg ? '0 : disc[2*RW-1:0];
      sbr <= sbr_next;
    end
  end

  // Square root of the discriminant.
  logic [RW-1:0] root;
  sb_r_t         sbs;
  logic          vs;

  rusi_sqrt #(
    .RW (RW),
    .SW ($bits(sb_r_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vr),
    .rad       (rad),
    .in_side   (sbr),
    .out_valid (vs),
    .root      (root),
    .out_side  (sbs)
  );

  // Numerator: -B + R inside the sphere, -B - R outside (R is zero when tangent).
  logic signed [NSW-1:0] b_ext, r_ext, nval, nabs;
  vec3_t                 dmag_w, dmag;
  logic [NMW-1:0]        nmag;
  sb_p_t                 sbp_next, sbp;
  logic                  vn;

  always_comb begin
    b_ext = $signed(sbs.b);
    r_ext = {{(NSW-RW){1'b0}}, root};
    if (sbs.c_neg) begin
      nval = r_ext - b_ext;
    end else begin
      nval = -r_ext - b_ext;
    end
    nabs = nval[NSW-1] ? -nval : nval;
    for (int i = 0; i < 3; i++) begin
      dmag_w[i]       = sbs.d[i][CW-1] ? -sbs.d[i] : sbs.d[i];
      sbp_next.neg[i] = sbs.d[i][CW-1] ^ nval[NSW-1];
    end
    sbp_next.o      = sbs.o;
    sbp_next.a      = sbs.a;
    sbp_next.hit    = sbs.hit;
    sbp_next.c_zero = sbs.c_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (en) begin
      vn <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nmag <= nabs[NMW-1:0];
      dmag <= dmag_w;
      sbp  <= sbp_next;
    end
  end

  // Products |d_i| * |N|.
  logic [2:0][PMW-1:0] pprod;
  sb_p_t               sbp2;
  logic                vp;

  rusi_mul #(
    .LANES (3),
    .AW    (CW),
    .BW    (NMW),
    .LB    (LIMB),
    .SW    ($bits(sb_p_t))
  ) u_mul_impact (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vn),
    .a         (dmag),
    .b         ({nmag, nmag, nmag}),
    .in_side   (sbp),
    .out_valid (vp),
    .p         (pprod),
    .out_side  (sbp2)
  );

  // Rounded quotient floor((2|p| + A) / 2A), which rounds half away from zero.
  logic [2:0][NUMW-1:0] num;
  sb_q_t                sbq_in, sbo;
  logic [2:0][QB-1:0]   quo;
  logic [2:0]           ovf;
  logic                 vq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {pprod[i], 1'b0} + NUMW'(sbp2.a);
    end
    sbq_in.o      = sbp2.o;
    sbq_in.neg    = sbp2.neg;
    sbq_in.hit    = sbp2.hit;
    sbq_in.c_zero = sbp2.c_zero;
  end

  rusi_div #(
    .LANES (3),
    .NUMW  (NUMW),
    .DENW  (DENW),
    .QB    (QB),
    .SW    ($bits(sb_q_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vp),
    .num       (num),
    .den       ({sbp2.a, 1'b0}),
    .in_side   (sbq_in),
    .out_valid (vq),
    .q         (quo),
    .ovf       (ovf),
    .out_side  (sbo)
  );

  // Impact point with saturation, and the miss and on-surface cases.
  impact_t fin;

  always_comb begin
    logic [UW-1:0] qext, qs, oext, u;
    vec3_t         co;
    logic          sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qext = {2'b00, quo[i]};
      qs   = sbo.neg[i] ? -qext : qext;
      oext = {{(UW-CW){sbo.o[i][CW-1]}}, sbo.o[i]};
      u    = oext + qs;
      if (ovf[i]) begin
        co[i] = sbo.neg[i] ? COORD_MIN : COORD_MAX;
        sat   = 1'b1;
      end else if (!u[UW-1] && (|u[UW-2:CW-1])) begin
        co[i] = COORD_MAX;
        sat   = 1'b1;
      end else if (u[UW-1] && !(&u[UW-2:CW-1])) begin
        co[i] = COORD_MIN;
        sat   = 1'b1;
      end else begin
        co[i] = u[CW-1:0];
      end
    end
    fin = '0;
    if (sbo.hit) begin
      fin.hit = 1'b1;
      if (sbo.c_zero) begin
        fin.impact_x = sbo.o[0];
        fin.impact_y = sbo.o[1];
        fin.impact_z = sbo.o[2];
      end else begin
        fin.impact_x  = co[0];
        fin.impact_y  = co[1];
        fin.impact_z  = co[2];
        fin.saturated = sat;
      end
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (skid_full) begin
      if (!result_stall) begin
        result_valid <= 1'b1;
        skid_full    <= 1'b0;
      end
    end else if (!result_valid || !result_stall) begin
      result_valid <= vq;
    end else if (vq) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (!result_stall) begin
        result <= skid;
      end
    end else if (!result_valid || !result_stall) begin
      result <= fin;
    end else begin
      skid <= fin;
    end
  end

  // The skid register only ever holds an item behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> result_valid)
    else $error("skid register full while the output register is empty");

  // The skid register fills only when the receiver stalled a waiting item.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(result_valid && result_stall))
    else $error("skid register filled without an output stall");

  // A miss carries a zero impact and no saturation.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit) |->
      (result.impact_x == '0 && result.impact_y == '0 &&
       result.impact_z == '0 && !result.saturated))
    else $error("miss item with a non-zero payload");

endmodule

// ===== hw/rtl/rusi_mul.sv =====
// Pipelined unsigned multiplier, several lanes in step, one limb of b per stage.
// Carries an opaque sideband alongside. No package dependency.
module rusi_mul #(
  parameter int LANES = 1,
  parameter int AW    = 32,
  parameter int BW    = 32,
  parameter int LB    = 16,
  parameter int SW    = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [LANES-1:0][AW-1:0]     a,
  input  logic [LANES-1:0][BW-1:0]     b,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [LANES-1:0][AW+BW-1:0]  p,
  output logic [SW-1:0]                out_side
);

  localparam int NS = (BW + LB - 1) / LB;
  localparam int BP = NS * LB;
  localparam int PW = AW + BW;

  logic [NS-1:0]               vld, vld_next;
  logic [LANES-1:0][AW-1:0]    a_r [NS];
  logic [LANES-1:0][AW-1:0]    a_next [NS];
  logic [LANES-1:0][BP-1:0]    b_r [NS];
  logic [LANES-1:0][BP-1:0]    b_next [NS];
  logic [LANES-1:0][PW-1:0]    acc [NS];
  logic [LANES-1:0][PW-1:0]    acc_next [NS];
  logic [SW-1:0]               side_r [NS];
  logic [SW-1:0]               side_next [NS];

  // Each stage adds one limb's partial product into the running sum.
  always_comb begin
    logic [LANES-1:0][PW-1:0] acc_in;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        vld_next[s]  = in_valid;
        side_next[s] = in_side;
        a_next[s]    = a;
        for (int l = 0; l < LANES; l++) begin
          b_next[s][l] = BP'(b[l]);
        end
        acc_in = '0;
      end else begin
        vld_next[s]  = vld[s-1];
        side_next[s] = side_r[s-1];
        a_next[s]    = a_r[s-1];
        b_next[s]    = b_r[s-1];
        acc_in       = acc[s-1];
      end
      for (int l = 0; l < LANES; l++) begin
        acc_next[s][l] = acc_in[l] +
                         ((PW'(a_next[s][l]) * PW'(b_next[s][l][s*LB +: LB])) << (s * LB));
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= vld_next;
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_next;
      b_r    <= b_next;
      acc    <= acc_next;
      side_r <= side_next;
    end
  end

  assign out_valid = vld[NS-1];
  assign p         = acc[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// ===== hw/rtl/rusi_sqrt.sv =====
// Pipelined integer square root, one root bit per stage (digit by digit).
// Carries an opaque sideband alongside. No package dependency.
module rusi_sqrt #(
  parameter int RW = 48,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   out_side
);

  localparam int NS  = RW;
  localparam int RMW = RW + 2;

  logic [NS-1:0]     vld, vld_next;
  logic [2*RW-1:0]   rad_r [NS];
  logic [2*RW-1:0]   rad_next [NS];
  logic [RMW-1:0]    rem_r [NS];
  logic [RMW-1:0]    rem_next [NS];
  logic [RW-1:0]     root_r [NS];
  logic [RW-1:0]     root_next [NS];
  logic [SW-1:0]     side_r [NS];
  logic [SW-1:0]     side_next [NS];

  // Each stage brings down two radicand bits and decides one root bit.
  always_comb begin
    logic [RMW-1:0] rem_in, remsh, trial;
    logic [RW-1:0]  root_in;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        vld_next[s]  = in_valid;
        side_next[s] = in_side;
        rad_next[s]  = rad;
        rem_in       = '0;
        root_in      = '0;
      end else begin
        vld_next[s]  = vld[s-1];
        side_next[s] = side_r[s-1];
        rad_next[s]  = rad_r[s-1];
        rem_in       = rem_r[s-1];
        root_in      = root_r[s-1];
      end
      remsh = {rem_in[RMW-3:0], rad_next[s][2*(RW-1-s) +: 2]};
      trial = {root_in, 2'b01};
      if (remsh >= trial) begin
        rem_next[s]  = remsh - trial;
        root_next[s] = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_next[s]  = remsh;
        root_next[s] = {root_in[RW-2:0], 1'b0};
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= vld_next;
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_next;
      rem_r  <= rem_next;
      root_r <= root_next;
      side_r <= side_next;
    end
  end

  assign out_valid = vld[NS-1];
  assign root      = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

// ===== hw/rtl/rusi_div.sv =====
// Pipelined restoring divider, several numerators over one shared divisor.
// Flags a quotient that needs more than QB bits. No package dependency.
module rusi_div #(
  parameter int LANES = 1,
  parameter int NUMW  = 64,
  parameter int DENW  = 32,
  parameter int QB    = 32,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NUMW-1:0] num,
  input  logic [DENW-1:0]            den,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QB-1:0]   q,
  output logic [LANES-1:0]           ovf,
  output logic [SW-1:0]              out_side
);

  localparam int NS = QB + 1;

  logic [NS-1:0]                vld, vld_next;
  logic [DENW-1:0]              den_r [NS];
  logic [DENW-1:0]              den_next [NS];
  logic [LANES-1:0][DENW-1:0]   rem_r [NS];
  logic [LANES-1:0][DENW-1:0]   rem_next [NS];
  logic [LANES-1:0][QB-1:0]     lo_r [NS];
  logic [LANES-1:0][QB-1:0]     lo_next [NS];
  logic [LANES-1:0][QB-1:0]     q_r [NS];
  logic [LANES-1:0][QB-1:0]     q_next [NS];
  logic [LANES-1:0]             ovf_r [NS];
  logic [LANES-1:0]             ovf_next [NS];
  logic [SW-1:0]                side_r [NS];
  logic [SW-1:0]                side_next [NS];

  // The first stage checks the quotient range and seeds the remainder with the
  // high numerator bits; each later stage produces one quotient bit.
  always_comb begin
    logic [DENW:0] t, dext;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        vld_next[s]  = in_valid;
        side_next[s] = in_side;
        den_next[s]  = den;
        for (int l = 0; l < LANES; l++) begin
          ovf_next[s][l] = (num[l] >> QB) >= NUMW'(den);
          rem_next[s][l] = DENW'(num[l] >> QB);
          lo_next[s][l]  = num[l][QB-1:0];
          q_next[s][l]   = '0;
        end
      end else begin
        vld_next[s]  = vld[s-1];
        side_next[s] = side_r[s-1];
        den_next[s]  = den_r[s-1];
        ovf_next[s]  = ovf_r[s-1];
        lo_next[s]   = lo_r[s-1];
        dext         = {1'b0, den_r[s-1]};
        for (int l = 0; l < LANES; l++) begin
          t = {rem_r[s-1][l], lo_r[s-1][l][QB-s]};
          if (t >= dext) begin
            rem_next[s][l] = DENW'(t - dext);
            q_next[s][l]   = {q_r[s-1][l][QB-2:0], 1'b1};
          end else begin
            rem_next[s][l] = t[DENW-1:0];
            q_next[s][l]   = {q_r[s-1][l][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= vld_next;
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_next;
      rem_r  <= rem_next;
      lo_r   <= lo_next;
      q_r    <= q_next;
      ovf_r  <= ovf_next;
      side_r <= side_next;
    end
  end

  assign out_valid = vld[NS-1];
  assign q         = q_r[NS-1];
  assign ovf       = ovf_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule
